[rtl/fleet_update_sequencer_defines.svh]
// Assertion macros shared by the fleet update sequencer RTL.
`ifndef FLEET_UPDATE_SEQUENCER_DEFINES_SVH
`define FLEET_UPDATE_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF

`define FUS_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fleet_update_sequencer: same-cycle check failed");

`define FUS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fleet_update_sequencer: next-cycle check failed");

`else

`define FUS_ASSERT_IMPLIES(label, clk, rstn, ante, cons)

`define FUS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[rtl/fus_pkg.sv]
// Types, codes and beat layouts of the fleet update sequencer.
`default_nettype none

package fus_pkg;

    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 48;
    localparam int CMD_W       = 3;
    localparam int ACT_W       = 3;
    localparam int PHASE_W     = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD_ZONE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ACK       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SUBMITTED = 3'd5;

    localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_START    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DONE     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FAILED   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ACCEPTED = 3'd4;
    localparam logic [ACT_W-1:0] ACT_BUSY     = 3'd5;
    localparam logic [ACT_W-1:0] ACT_INVALID  = 3'd6;

    localparam logic [PHASE_W-1:0] PH_PRECHECK = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT_ACK = 2'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT_HB  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TIME    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_UPTIME_LIMIT = 2'd1;

    localparam logic [31:0] HOLD_TIME_RESET    = 32'd180000;
    localparam logic [31:0] UPTIME_LIMIT_RESET = 32'd60;

    // Input beat payload; the last member sits in the lowest bits.
    typedef struct packed {
        logic [6:0]  pad;
        logic        success;
        logic [15:0] seq;
        logic [31:0] hb_arrival;
        logic [31:0] hb_up_secs;
        logic [23:0] fw_version;
        logic        hb_seen;
        logic        online;
        logic        image_good;
        logic [7:0]  zone_id;
        logic [4:0]  zone_number;
        logic [31:0] now_ms;
    } in_data_t;

    // Result beat payload; the last member sits in the lowest bits.
    typedef struct packed {
        logic [4:0]         pad;
        logic [7:0]         current_zone;
        logic [PHASE_W-1:0] run_phase;
        logic               run_active;
        logic [23:0]        new_version;
        logic [7:0]         action_zone;
    } out_data_t;

endpackage

`default_nettype wire

[rtl/fus_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none

module fus_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                      aclk,
    input  wire                                      wr_en,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]                         wr_data,
    input  wire                                      rd_en,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/fleet_update_sequencer.sv]
// Top level of the fleet update sequencer: event decode, run state and result register.
`default_nettype none

`include "fleet_update_sequencer_defines.svh"

// The sequencer takes one event beat per cycle and returns exactly one result beat for
// each, in the cycle after the event is accepted; a new event is taken in the same cycle
// that the previous result is taken, so with the result side ready it sustains one beat
// per cycle. All decisions for an event are made in one pass of compare logic between the
// input handshake and the result register. The zone list lives in a small RAM whose
// registered read port follows the current zone position, so the current zone identifier
// of a result beat is read out of that port. Configuration writes are accepted in every
// cycle outside reset, and no event beat is taken while reset is held.
module fleet_update_sequencer #(
    parameter int MAX_ZONES = 16
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  wire                                      s_tvalid,
    output logic                                     s_tready,
    // now_ms, zone_number, zone_id, image_good, online, hb_seen, fw_version, hb_up_secs,
    // hb_arrival, seq, success, zero pad
    input  wire  [fus_pkg::IN_TDATA_W-1:0]           s_tdata,
    // command
    input  wire  [fus_pkg::CMD_W-1:0]                s_tuser,
    output logic                                     m_tvalid,
    input  wire                                      m_tready,
    // action_zone, new_version, run_active, run_phase, current_zone, zero pad
    output logic [fus_pkg::OUT_TDATA_W-1:0]          m_tdata,
    // action
    output logic [fus_pkg::ACT_W-1:0]                m_tuser,
    input  wire                                      cfg_valid,
    output logic                                     cfg_ready,
    input  wire  [fus_pkg::CFG_INDEX_W-1:0]          cfg_index,
    input  wire  [fus_pkg::CFG_DATA_W-1:0]           cfg_data
);

    localparam int PW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam logic [31:0] MAX_ZONES_U = 32'(MAX_ZONES);

    fus_pkg::in_data_t in_d;
    fus_pkg::out_data_t out_d;

    logic                         s_accept;
    logic [31:0]                  hold_time_reg;
    logic [31:0]                  uptime_limit_reg;

    logic [4:0]                   total_reg, total_next;
    logic [PW-1:0]                pos_reg, pos_next;
    logic                         running_reg, running_next;
    logic [fus_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic                         cancel_reg, cancel_next;
    logic [15:0]                  exp_seq_reg, exp_seq_next;
    logic [31:0]                  deadline_reg, deadline_next;
    logic [31:0]                  ack_time_reg, ack_time_next;
    logic [23:0]                  old_version_reg, old_version_next;

    logic                         m_tvalid_reg;
    logic [fus_pkg::ACT_W-1:0]    out_action_reg, out_action_next;
    logic [7:0]                   out_zone_reg, out_zone_next;
    logic [23:0]                  out_version_reg, out_version_next;
    logic                         out_active_reg;
    logic [fus_pkg::PHASE_W-1:0]  out_phase_reg;

    logic                         load_en;
    logic [7:0]                   zone_q;
    logic [31:0]                  arrive_diff;
    logic [31:0]                  deadline_diff;
    logic                         last_zone;
    logic                         hb_fresh;
    logic                         hb_confirms;

    assign in_d      = fus_pkg::in_data_t'(s_tdata);
    assign s_tready  = aresetn && (!m_tvalid_reg || m_tready);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = aresetn;

    assign arrive_diff   = in_d.hb_arrival - ack_time_reg;
    assign deadline_diff = in_d.now_ms - deadline_reg;
    assign last_zone     = (32'(pos_reg) + 32'd1) >= 32'(total_reg);
    assign hb_fresh      = in_d.hb_seen && (arrive_diff != 32'd0) && !arrive_diff[31];
    assign hb_confirms   = hb_fresh && ((in_d.fw_version != old_version_reg)
                                        || (in_d.hb_up_secs < uptime_limit_reg));

    always_comb begin
        total_next       = total_reg;
        pos_next         = pos_reg;
        running_next     = running_reg;
        phase_next       = phase_reg;
        cancel_next      = cancel_reg;
        exp_seq_next     = exp_seq_reg;
        deadline_next    = deadline_reg;
        ack_time_next    = ack_time_reg;
        old_version_next = old_version_reg;
        out_action_next  = fus_pkg::ACT_NONE;
        out_zone_next    = 8'd0;
        out_version_next = 24'd0;
        load_en          = 1'b0;
        case (s_tuser)
            fus_pkg::CMD_LOAD_ZONE: begin
                if (!running_reg && (32'(in_d.zone_number) < MAX_ZONES_U)) begin
                    load_en = 1'b1;
                end
            end
            fus_pkg::CMD_START: begin
                if (running_reg) begin
                    out_action_next = fus_pkg::ACT_BUSY;
                end else if ((in_d.zone_number == 5'd0)
                             || (32'(in_d.zone_number) > MAX_ZONES_U)) begin
                    out_action_next = fus_pkg::ACT_INVALID;
                end else begin
                    total_next       = in_d.zone_number;
                    pos_next         = '0;
                    running_next     = 1'b1;
                    phase_next       = fus_pkg::PH_PRECHECK;
                    cancel_next      = 1'b0;
                    exp_seq_next     = 16'd0;
                    deadline_next    = 32'd0;
                    ack_time_next    = 32'd0;
                    old_version_next = 24'd0;
                    out_action_next  = fus_pkg::ACT_ACCEPTED;
                end
            end
            fus_pkg::CMD_CANCEL: begin
                if (running_reg) begin
                    if (phase_reg == fus_pkg::PH_PRECHECK) begin
                        running_next = 1'b0;
                    end else begin
                        cancel_next = 1'b1;
                    end
                end
            end
            fus_pkg::CMD_TICK: begin
                if (running_reg && (phase_reg == fus_pkg::PH_PRECHECK)) begin
                    out_zone_next = zone_q;
                    if (!in_d.image_good || !in_d.online) begin
                        out_action_next = fus_pkg::ACT_FAILED;
                        running_next    = 1'b0;
                    end else begin
                        out_action_next = fus_pkg::ACT_START;
                        phase_next      = fus_pkg::PH_WAIT_ACK;
                    end
                end else if (running_reg && (phase_reg == fus_pkg::PH_WAIT_HB)) begin
                    if (hb_confirms) begin
                        out_action_next  = fus_pkg::ACT_DONE;
                        out_zone_next    = zone_q;
                        out_version_next = in_d.fw_version;
                        if (cancel_reg || last_zone) begin
                            running_next = 1'b0;
                        end else begin
                            pos_next   = pos_reg + PW'(1);
                            phase_next = fus_pkg::PH_PRECHECK;
                        end
                    end else if (!deadline_diff[31]) begin
                        out_action_next = fus_pkg::ACT_FAILED;
                        out_zone_next   = zone_q;
                        running_next    = 1'b0;
                    end
                end
            end
            fus_pkg::CMD_ACK: begin
                if (running_reg && (phase_reg == fus_pkg::PH_WAIT_ACK)
                    && (in_d.seq == exp_seq_reg)) begin
                    if (!in_d.success) begin
                        out_action_next = fus_pkg::ACT_FAILED;
                        out_zone_next   = zone_q;
                        running_next    = 1'b0;
                    end else begin
                        phase_next    = fus_pkg::PH_WAIT_HB;
                        ack_time_next = in_d.now_ms;
                    end
                end
            end
            fus_pkg::CMD_SUBMITTED: begin
                if (running_reg && (phase_reg == fus_pkg::PH_WAIT_ACK)) begin
                    if (!in_d.success) begin
                        out_action_next = fus_pkg::ACT_FAILED;
                        out_zone_next   = zone_q;
                        running_next    = 1'b0;
                    end else begin
                        exp_seq_next     = in_d.seq;
                        deadline_next    = in_d.now_ms + hold_time_reg;
                        old_version_next = in_d.fw_version;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    fus_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ZONES)
    ) u_zone_ram (
        .aclk    (aclk),
        .wr_en   (s_accept && load_en),
        .wr_addr (PW'(in_d.zone_number)),
        .wr_data (in_d.zone_id),
        .rd_en   (s_accept),
        .rd_addr (pos_next),
        .rd_data (zone_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_time_reg    <= fus_pkg::HOLD_TIME_RESET;
            uptime_limit_reg <= fus_pkg::UPTIME_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                fus_pkg::CFG_HOLD_TIME:    hold_time_reg    <= cfg_data;
                fus_pkg::CFG_UPTIME_LIMIT: uptime_limit_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg       <= 5'd0;
            pos_reg         <= '0;
            running_reg     <= 1'b0;
            phase_reg       <= fus_pkg::PH_PRECHECK;
            cancel_reg      <= 1'b0;
            exp_seq_reg     <= 16'd0;
            deadline_reg    <= 32'd0;
            ack_time_reg    <= 32'd0;
            old_version_reg <= 24'd0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (s_accept) begin
                total_reg       <= total_next;
                pos_reg         <= pos_next;
                running_reg     <= running_next;
                phase_reg       <= phase_next;
                cancel_reg      <= cancel_next;
                exp_seq_reg     <= exp_seq_next;
                deadline_reg    <= deadline_next;
                ack_time_reg    <= ack_time_next;
                old_version_reg <= old_version_next;
                m_tvalid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_action_reg  <= out_action_next;
            out_zone_reg    <= out_zone_next;
            out_version_reg <= out_version_next;
            out_active_reg  <= running_next;
            out_phase_reg   <= running_next ? phase_next : fus_pkg::PH_PRECHECK;
        end
    end

    // The zone RAM is read at the position left by the same beat, so its output
    // already holds the current zone while the result waits.
    always_comb begin
        out_d              = '0;
        out_d.action_zone  = out_zone_reg;
        out_d.new_version  = out_version_reg;
        out_d.run_active   = out_active_reg;
        out_d.run_phase    = out_phase_reg;
        out_d.current_zone = out_active_reg ? zone_q : 8'd0;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_d;
    assign m_tuser  = out_action_reg;

    `FUS_ASSERT_IMPLIES(a_phase_known, aclk, aresetn, running_reg,
        (phase_reg == fus_pkg::PH_PRECHECK) || (phase_reg == fus_pkg::PH_WAIT_ACK)
        || (phase_reg == fus_pkg::PH_WAIT_HB))
    `FUS_ASSERT_IMPLIES(a_pos_in_run, aclk, aresetn, running_reg,
        (32'(pos_reg) < 32'(total_reg)) && (32'(total_reg) <= MAX_ZONES_U))
    `FUS_ASSERT_NEXT(a_start_shows_run, aclk, aresetn,
        s_accept && (out_action_next == fus_pkg::ACT_ACCEPTED),
        m_tvalid_reg && out_active_reg && (out_phase_reg == fus_pkg::PH_PRECHECK))
    `FUS_ASSERT_NEXT(a_done_advances, aclk, aresetn,
        s_accept && (out_action_next == fus_pkg::ACT_DONE) && running_next,
        running_reg && (phase_reg == fus_pkg::PH_PRECHECK) && !cancel_reg)

endmodule

`default_nettype wire
